@@ design/ucb1_bandit_arm_selector_core_defines.svh @@
// ----------------------------------------------------------------------------
// UCB1 arm selector assertion macros
// Shared property forms for the selector core checks.
// ----------------------------------------------------------------------------
`ifndef UCB1_BANDIT_ARM_SELECTOR_CORE_DEFINES_SVH
`define UCB1_BANDIT_ARM_SELECTOR_CORE_DEFINES_SVH

// same-cycle implication
`define UCB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ucb1 check failed");

// next-cycle implication
`define UCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ucb1 check failed");

`endif

@@ design/ucb1_pkg.sv @@
// ----------------------------------------------------------------------------
// UCB1 arm selector package
// Payload types and sizing constants for the selector core.
// ----------------------------------------------------------------------------
package ucb1_pkg;

  localparam int MaxArms   = 64;
  localparam int ArmBits   = 6;
  localparam int CountBits = 20;
  localparam int DvdBits   = CountBits + 16;
  localparam int RootBits  = DvdBits / 2;
  localparam logic [15:0] Ln2Q16 = 16'd45426;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_OUTCOME = 1'b1;

  localparam logic [1:0] REG_ARMS   = 2'd0;
  localparam logic [1:0] REG_GAIN   = 2'd1;
  localparam logic [1:0] REG_BUDGET = 2'd2;

  typedef struct packed {
    logic command;
    logic won;
  } in_item_t;

  typedef struct packed {
    logic [ArmBits-1:0] arm;
    logic               is_final;
  } out_item_t;

endpackage

@@ design/ucb1_bandit_arm_selector_core.sv @@
// ----------------------------------------------------------------------------
// UCB1 arm selector core
// Picks the next bandit arm by UCB1 score, or the best arm once the budget
// is spent, using one shared multiplier, divider and square-root step unit.
// ----------------------------------------------------------------------------
// Use: send a start item (command 0) to clear the counts; each outcome item
// (command 1) credits the proposed arm. Every input item yields one result
// item: the arm to play next, or the final best arm with is_final set.
// Configuration writes go through cfg_valid/cfg_ready, always ready; the user
// must make them only while the block is idle, which the block does not enforce.
// Flow: a start item still runs the log of the zero total before arm 0 is
// found unplayed. An outcome item runs the count update and the log of the
// total play count, then for each arm scanned two 36-step divisions, an
// 18-step square root and a multiply, all on the shared unit; a final choice
// skips the log and runs one division per arm. in_ready is low while an item
// is at work. A waiting result sits in the output register; if the receiver
// stalls, the next finished result waits until it is taken.
// Reset clears all counts (per-arm valid bits), proposes arm 0 and loads
// the register defaults.
// ----------------------------------------------------------------------------
`include "ucb1_bandit_arm_selector_core_defines.svh"

module ucb1_bandit_arm_selector_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ucb1_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ucb1_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [19:0]       cfg_data
);

  localparam int AB = ucb1_pkg::ArmBits;
  localparam int CB = ucb1_pkg::CountBits;
  localparam int DB = ucb1_pkg::DvdBits;
  localparam int RB = ucb1_pkg::RootBits;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UPD_RD = 4'd1;
  localparam logic [3:0] S_UPD_WR = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_LOG_MUL  = 4'd4;
  localparam logic [3:0] S_LOG_NORM = 4'd5;
  localparam logic [3:0] S_LN_MUL = 4'd6;
  localparam logic [3:0] S_LN_DONE = 4'd7;
  localparam logic [3:0] S_ARM_RD = 4'd8;
  localparam logic [3:0] S_ARM_EV = 4'd9;
  localparam logic [3:0] S_DIV_R  = 4'd10;
  localparam logic [3:0] S_DIV_Q  = 4'd11;
  localparam logic [3:0] S_SQRT   = 4'd12;
  localparam logic [3:0] S_BONUS  = 4'd13;
  localparam logic [3:0] S_CMP    = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  // config
  logic [6:0]  arms_r;
  logic [15:0] gain_r;
  logic [CB-1:0] budget_r;

  logic [3:0]    state_r;
  logic [CB-1:0] total_r;
  logic [AB-1:0] prop_r;
  logic [AB-1:0] idx_r;
  logic [AB-1:0] best_r;
  logic [DB:0]   bestv_r;
  logic [DB:0]   val_r;
  logic          final_r;
  logic [AB-1:0] res_arm_r;
  logic          in_won_r;

  // count store: {plays, wins}
  logic [2*CB-1:0] mem [ucb1_pkg::MaxArms];
  logic [ucb1_pkg::MaxArms-1:0] valid_r;
  logic [2*CB-1:0] rd_data_r;
  logic            rd_valid_r;
  logic [AB-1:0]   mem_addr;
  logic [CB-1:0]   rd_plays, rd_wins, plays_inc, wins_inc;

  // shared arithmetic
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r;
  logic [30:0] y_r;
  logic [4:0]  n_r;
  logic [15:0] frac_r;
  logic [5:0]  cnt_r;
  logic [CB-1:0] ln_r;
  logic [DB-1:0] dvd_r;
  logic [CB-1:0] dsor_r;
  logic [CB-1:0] rem_r;
  logic [RB-1:0] root_r;
  logic [RB+2:0] srem_r;

  logic          out_valid_r;
  ucb1_pkg::out_item_t out_data_r;

  logic [6:0]    act;
  logic [AB-1:0] last;
  logic [4:0]    msb;
  logic [CB:0]   rem_sh;
  logic [31:0]   yy;
  logic [RB+4:0] s_sh;
  logic [RB+1:0] s_trial;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    act = arms_r;
    if (arms_r == 7'd0) act = 7'd1;
    if (arms_r > 7'(ucb1_pkg::MaxArms)) act = 7'(ucb1_pkg::MaxArms);
  end
  assign last = AB'(act - 7'd1);

  always_comb begin
    msb = 5'd0;
    for (int b = 0; b < CB; b++) begin
      if (total_r[b]) msb = 5'(b);
    end
  end

  assign mem_addr = (state_r == S_UPD_RD) ? prop_r : idx_r;
  assign rd_plays = rd_valid_r ? rd_data_r[2*CB-1:CB] : '0;
  assign rd_wins  = rd_valid_r ? rd_data_r[CB-1:0] : '0;
  assign plays_inc = (&rd_plays) ? rd_plays : rd_plays + 1'b1;
  assign wins_inc  = (in_won_r && !(&rd_wins)) ? rd_wins + 1'b1 : rd_wins;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_LOG_MUL: begin
        mul_a = {1'b0, y_r};
        mul_b = {1'b0, y_r};
      end
      S_LN_MUL: begin
        mul_a = 32'({n_r, frac_r});
        mul_b = 32'(ucb1_pkg::Ln2Q16);
      end
      default: begin
        mul_a = 32'(gain_r);
        mul_b = 32'(root_r);
      end
    endcase
  end

  assign yy      = prod_r[61:30];
  assign rem_sh  = {rem_r, dvd_r[DB-1]};
  assign s_sh    = {srem_r, dvd_r[DB-1 -: 2]};
  assign s_trial = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    rd_data_r <= mem[mem_addr];
    rd_valid_r <= valid_r[mem_addr];
    if (state_r == S_UPD_WR) begin
      mem[prop_r] <= {plays_inc, wins_inc};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arms_r      <= 7'd2;
      gain_r      <= 16'd5793;
      budget_r    <= CB'(1000);
      state_r     <= S_IDLE;
      total_r     <= '0;
      prop_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ucb1_pkg::REG_ARMS:   arms_r   <= cfg_data[6:0];
          ucb1_pkg::REG_GAIN:   gain_r   <= cfg_data[15:0];
          ucb1_pkg::REG_BUDGET: budget_r <= cfg_data[CB-1:0];
          default: ;
        endcase
      end
      // in S_DONE the output register is reloaded below instead
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_won_r <= in_data.won;
            if (in_data.command == ucb1_pkg::CMD_START) begin
              valid_r <= '0;
              total_r <= '0;
              state_r <= S_CHECK;
            end else if (total_r < budget_r) begin
              state_r <= S_UPD_RD;
            end else begin
              state_r <= S_CHECK;
            end
          end
        end
        S_UPD_RD: state_r <= S_UPD_WR;
        S_UPD_WR: begin
          valid_r[prop_r] <= 1'b1;
          if (!(&total_r)) total_r <= total_r + 1'b1;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          final_r <= (total_r >= budget_r);
          idx_r   <= '0;
          n_r     <= msb;
          y_r     <= 31'(total_r) << (5'd30 - msb);
          frac_r  <= '0;
          cnt_r   <= '0;
          state_r <= (total_r >= budget_r) ? S_ARM_RD : S_LOG_MUL;
        end
        S_LOG_MUL: state_r <= S_LOG_NORM;
        S_LOG_NORM: begin
          // squaring step of the mantissa gives one fraction bit of log2
          if (yy[31]) begin
            y_r    <= yy[31:1];
            frac_r <= {frac_r[14:0], 1'b1};
          end else begin
            y_r    <= yy[30:0];
            frac_r <= {frac_r[14:0], 1'b0};
          end
          cnt_r   <= cnt_r + 1'b1;
          state_r <= (cnt_r == 6'd15) ? S_LN_MUL : S_LOG_MUL;
        end
        S_LN_MUL: state_r <= S_LN_DONE;
        S_LN_DONE: begin
          ln_r    <= prod_r[16 +: CB];
          state_r <= S_ARM_RD;
        end
        S_ARM_RD: state_r <= S_ARM_EV;
        S_ARM_EV: begin
          dsor_r <= rd_plays;
          rem_r  <= '0;
          cnt_r  <= '0;
          dvd_r  <= {rd_wins, 16'd0};
          if (rd_plays == '0) begin
            if (final_r) begin
              val_r   <= '0;
              state_r <= S_CMP;
            end else begin
              res_arm_r <= idx_r;
              prop_r    <= idx_r;
              state_r   <= S_DONE;
            end
          end else begin
            state_r <= S_DIV_R;
          end
        end
        S_DIV_R, S_DIV_Q: begin
          if (rem_sh >= {1'b0, dsor_r}) begin
            rem_r <= CB'(rem_sh - {1'b0, dsor_r});
            dvd_r <= {dvd_r[DB-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[CB-1:0];
            dvd_r <= {dvd_r[DB-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 6'(DB-1)) begin
            cnt_r <= '0;
            if (state_r == S_DIV_R) begin
              val_r <= {1'b0, dvd_r[DB-2:0], (rem_sh >= {1'b0, dsor_r})};
              if (final_r) begin
                state_r <= S_CMP;
              end else begin
                dvd_r   <= {ln_r, 16'd0};
                rem_r   <= '0;
                state_r <= S_DIV_Q;
              end
            end else begin
              root_r  <= '0;
              srem_r  <= '0;
              state_r <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          // one result bit per step, two operand bits consumed
          if (s_sh >= (RB+5)'(s_trial)) begin
            srem_r <= (RB+3)'(s_sh - (RB+5)'(s_trial));
            root_r <= {root_r[RB-2:0], 1'b1};
          end else begin
            srem_r <= s_sh[RB+2:0];
            root_r <= {root_r[RB-2:0], 1'b0};
          end
          dvd_r <= {dvd_r[DB-3:0], 2'b00};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 6'(RB-1)) state_r <= S_BONUS;
        end
        S_BONUS: begin
          // the final root is multiplied into the registered prod_r, which is read in the cycle after
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 6'(RB+1)) begin
            val_r   <= val_r + (DB+1)'(prod_r[12 +: 22]);
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (idx_r == '0 || val_r > bestv_r) begin
            best_r  <= idx_r;
            bestv_r <= val_r;
          end
          if (idx_r == last) begin
            if (idx_r == '0 || val_r > bestv_r) begin
              res_arm_r <= idx_r;
              if (!final_r) prop_r <= idx_r;
            end else begin
              res_arm_r <= best_r;
              if (!final_r) prop_r <= best_r;
            end
            state_r <= S_DONE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_ARM_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r         <= 1'b1;
            out_data_r.arm      <= res_arm_r;
            out_data_r.is_final <= final_r;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `UCB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `UCB_ASSERT_NEXT(a_div_ends, state_r == S_DIV_Q && cnt_r == 6'(DB-1), state_r == S_SQRT)
  `UCB_ASSERT_NOW(a_out_only_when_free, state_r == S_DONE && out_valid_r && !out_ready,
                  !in_ready)

endmodule
